[rtl/skl_pkg.sv]
// Package for the sorted key list: request and response payload types,
// command and status codes, controller states and control structs.
// No dependencies.
`default_nettype none

package skl_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int KEY_FIELD_WIDTH   = 32;
   localparam int COUNT_FIELD_WIDTH = 5;
   localparam int STATUS_WIDTH      = 2;
   // Widest key the store supports; used to widen and narrow keys.
   localparam int MAX_KEY_WIDTH     = 64;

   // Request commands.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic                               command;
      logic signed [KEY_FIELD_WIDTH-1:0]  key;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]            status;
      logic [COUNT_FIELD_WIDTH-1:0]       entry_count;
      logic                               list_empty;
      logic signed [KEY_FIELD_WIDTH-1:0]  smallest_key;
   } rsp_payload_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_COMMIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // capture the request
      logic compare;   // register per-cell compare results
      logic reduce;    // register the found flag
      logic commit;    // load the response register
      logic write_en;  // apply the insert or remove to the cells
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_remove;
      logic full;
      logic found;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/skl_ctrl.sv]
// Controller of the sorted key list: sequences compare, reduce and commit
// for one request and owns the request and response handshakes.
// Depends on skl_pkg.
`default_nettype none

module skl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output skl_pkg::dp_cmd_type        dp_cmd,
   input  wire skl_pkg::dp_status_type dp_status
);

   skl_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in        = state_ff;
      dp_cmd          = '0;
      req_ready       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         skl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = skl_pkg::ST_COMPARE;
            end
         end
         skl_pkg::ST_COMPARE: begin
            dp_cmd.compare = 1'b1;
            state_in       = skl_pkg::ST_REDUCE;
         end
         skl_pkg::ST_REDUCE: begin
            dp_cmd.reduce = 1'b1;
            state_in      = skl_pkg::ST_COMMIT;
         end
         skl_pkg::ST_COMMIT: begin
            // Wait until the response register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.commit   = 1'b1;
               dp_cmd.write_en = dp_status.is_remove ? dp_status.found : !dp_status.full;
               rsp_valid_in    = 1'b1;
               state_in        = skl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/skl_datapath.sv]
// Datapath of the sorted key list: a row of key cells with per-cell
// compare logic, the entry count and the response register.
// Depends on skl_pkg.
`default_nettype none

module skl_datapath #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire skl_pkg::req_payload_type req_payload,
   output skl_pkg::rsp_payload_type     rsp_payload,
   input  wire skl_pkg::dp_cmd_type     dp_cmd,
   output skl_pkg::dp_status_type       dp_status
);

   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam int WideCount  = (CountWidth > skl_pkg::COUNT_FIELD_WIDTH) ?
                               CountWidth : skl_pkg::COUNT_FIELD_WIDTH;

   logic [KEY_WIDTH-1:0]  cell_ff [DEPTH];
   logic [KEY_WIDTH-1:0]  cell_in [DEPTH];
   logic [DEPTH-1:0]      valid;
   logic [DEPTH-1:0]      less_ff;
   logic [DEPTH-1:0]      match_ff;
   logic [DEPTH-1:0]      lt;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  command_ff;
   logic [KEY_WIDTH-1:0]  key_ff;
   logic                  found_ff;
   logic                  full;
   logic [skl_pkg::MAX_KEY_WIDTH-1:0] key_wide;
   logic [skl_pkg::MAX_KEY_WIDTH-1:0] smallest_wide;
   logic [WideCount-1:0]  count_wide;
   skl_pkg::rsp_payload_type rsp_ff, rsp_in;

   // Request capture; the key is sign-extended, then cut to the key width.
   assign key_wide = skl_pkg::MAX_KEY_WIDTH'(req_payload.key);

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         command_ff <= req_payload.command;
         key_ff     <= key_wide[KEY_WIDTH-1:0];
      end
   end

   // Per-cell compare against the captured key, registered.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      assign valid[i] = (count_ff > CountWidth'(i));
      assign lt[i]    = valid[i] && less_ff[i];

      always_ff @(posedge clock) begin
         if (dp_cmd.compare) begin
            less_ff[i]  <= ($signed(cell_ff[i]) < $signed(key_ff));
            match_ff[i] <= valid[i] && (cell_ff[i] == key_ff);
         end
      end
   end

   // Found flag for remove.
   always_ff @(posedge clock) begin
      if (dp_cmd.reduce) begin
         found_ff <= |match_ff;
      end
   end

   assign full = (count_ff == CountWidth'(DEPTH));

   assign dp_status.is_remove = (command_ff == skl_pkg::CMD_REMOVE);
   assign dp_status.full      = full;
   assign dp_status.found     = found_ff;

   // Next cell values: insert opens a slot at the first cell not below the
   // key; remove shifts down from the first cell not below the key.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         always_comb begin
            if (command_ff == skl_pkg::CMD_REMOVE) begin
               if (!less_ff[0] && DEPTH > 1) cell_in[0] = cell_ff[1 % DEPTH];
               else                          cell_in[0] = cell_ff[0];
            end else begin
               if (lt[0]) cell_in[0] = cell_ff[0];
               else       cell_in[0] = key_ff;
            end
         end
      end else if (i == DEPTH - 1) begin : g_last
         always_comb begin
            if (command_ff == skl_pkg::CMD_REMOVE) begin
               cell_in[i] = cell_ff[i];
            end else begin
               if (lt[i])          cell_in[i] = cell_ff[i];
               else if (lt[i - 1]) cell_in[i] = key_ff;
               else                cell_in[i] = cell_ff[i - 1];
            end
         end
      end else begin : g_mid
         always_comb begin
            if (command_ff == skl_pkg::CMD_REMOVE) begin
               if (!less_ff[i]) cell_in[i] = cell_ff[i + 1];
               else             cell_in[i] = cell_ff[i];
            end else begin
               if (lt[i])          cell_in[i] = cell_ff[i];
               else if (lt[i - 1]) cell_in[i] = key_ff;
               else                cell_in[i] = cell_ff[i - 1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (dp_cmd.write_en) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (dp_cmd.write_en) begin
         if (command_ff == skl_pkg::CMD_REMOVE) count_in = count_ff - 1'b1;
         else                                   count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response built from the state after this request.
   always_comb begin
      smallest_wide                = '0;
      smallest_wide[KEY_WIDTH-1:0] = cell_in[0];
      if (!dp_cmd.write_en) smallest_wide[KEY_WIDTH-1:0] = cell_ff[0];
      count_wide = WideCount'(count_in);

      rsp_in.entry_count = count_wide[skl_pkg::COUNT_FIELD_WIDTH-1:0];
      rsp_in.list_empty  = (count_in == '0);
      if (count_in == '0) rsp_in.smallest_key = '0;
      else rsp_in.smallest_key = smallest_wide[skl_pkg::KEY_FIELD_WIDTH-1:0];

      if (dp_cmd.write_en)                       rsp_in.status = skl_pkg::STATUS_DONE;
      else if (command_ff == skl_pkg::CMD_REMOVE) rsp_in.status = skl_pkg::STATUS_NOT_FOUND;
      else                                       rsp_in.status = skl_pkg::STATUS_FULL;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/sorted_key_list.sv]
// Sorted key list: keeps up to DEPTH signed keys in ascending order.
// Each request passes through capture, per-cell compare, found reduction
// and commit; commit waits until the response register is free, loads it
// and raises rsp_valid, and only then is a new request accepted.
// Reset clears the entry count and the handshake state; no clearing pass.
// Depends on skl_pkg, skl_ctrl and skl_datapath.
`default_nettype none

module sorted_key_list #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire skl_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output skl_pkg::rsp_payload_type     rsp_payload
);

   skl_pkg::dp_cmd_type    dp_cmd;
   skl_pkg::dp_status_type dp_status;

   // Sequencer.
   skl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // Key cells and response register.
   skl_datapath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_list: a directed table, then random
// insert and remove requests checked against a shadow copy of the key store.
// Depends on skl_pkg and the sorted_key_list RTL.

module tb;
   import skl_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int LIST_DEPTH      = 16;
   localparam int RANDOM_ITEMS    = 1330;
   localparam int MAX_GAP         = 6;
   localparam int HOLD_OFF_AT     = 200;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef struct {
      req_payload_type op;
      bit              typed;
      rsp_payload_type want;
   } stim_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   // Shadow copy of the key store, kept in ascending signed order.
   logic signed [KEY_FIELD_WIDTH-1:0] shadow_keys [LIST_DEPTH];
   int                                shadow_count;

   rsp_payload_type awaited_responses[$];
   stim_row_type    directed_rows[$];
   rsp_payload_type got_rsp;
   int              error_count;
   int              requests_sent;
   int              results_seen;
   int              idle_cycles;

   sorted_key_list #(
      .DEPTH(LIST_DEPTH),
      .KEY_WIDTH(KEY_FIELD_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one request to the shadow store and return the response it causes.
   function automatic rsp_payload_type predict_list_op(req_payload_type op);
      rsp_payload_type                   r;
      int                                pos;
      int                                i;
      logic signed [KEY_FIELD_WIDTH-1:0] k;
      k = op.key;
      r.status = STATUS_DONE;
      if (op.command == CMD_INSERT) begin
         if (shadow_count >= LIST_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // A new key goes after every held key that is strictly smaller.
            pos = 0;
            while (pos < shadow_count && shadow_keys[pos] < k) pos++;
            for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i - 1];
            shadow_keys[pos] = k;
            shadow_count++;
         end
      end else begin
         pos = shadow_count;
         for (i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == k) begin
               pos = i;
               break;
            end
         end
         if (pos >= shadow_count) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
            shadow_count--;
         end
      end
      r.entry_count  = COUNT_FIELD_WIDTH'(shadow_count);
      r.list_empty   = (shadow_count == 0);
      r.smallest_key = (shadow_count == 0) ? '0 : shadow_keys[0];
      return r;
   endfunction

   function automatic void add_row(logic cmd, logic [KEY_FIELD_WIDTH-1:0] key, bit typed,
                                   logic [STATUS_WIDTH-1:0] st, int count, bit empty,
                                   logic [KEY_FIELD_WIDTH-1:0] smallest);
      stim_row_type row;
      row.op.command        = cmd;
      row.op.key            = key;
      row.typed             = typed;
      row.want.status       = st;
      row.want.entry_count  = COUNT_FIELD_WIDTH'(count);
      row.want.list_empty   = empty;
      row.want.smallest_key = smallest;
      directed_rows.push_back(row);
   endfunction

   // Keys favor held values and a small pool so that removes often hit.
   function automatic logic [KEY_FIELD_WIDTH-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4 && shadow_count > 0) return shadow_keys[$urandom_range(0, shadow_count - 1)];
      if (sel < 7) return KEY_FIELD_WIDTH'($urandom_range(0, 8)) - 32'd4;
      if (sel < 8) begin
         case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom();
   endfunction

   // Offer one request after a random gap, then record its expected response.
   task automatic send_request(req_payload_type op, bit typed, rsp_payload_type want);
      int              gap;
      rsp_payload_type predicted;
      gap = ((requests_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= op;
      do @(posedge clock); while (!req_ready);
      predicted = predict_list_op(op);
      awaited_responses.push_back(typed ? want : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input longint unsigned want, got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Response checker: each accepted response is matched to the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_payload);
            error_count++;
         end else begin
            got_rsp = awaited_responses.pop_front();
            check_field("status", got_rsp.status, rsp_payload.status);
            check_field("entry_count", got_rsp.entry_count, rsp_payload.entry_count);
            check_field("list_empty", got_rsp.list_empty, rsp_payload.list_empty);
            check_field("smallest_key", got_rsp.smallest_key, rsp_payload.smallest_key);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a request or response.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Response receiver: random stalls, bursts without stalls, and one long hold-off.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if (results_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
         else if ((results_seen / 48) % 4 == 1) stall = 0;
         else stall = $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed table, random requests, drain and verdict.
   initial begin
      logic [KEY_FIELD_WIDTH-1:0] fill_keys [13];
      req_payload_type            op;
      rsp_payload_type            unused;
      int                         insert_pct;
      req_valid    = 1'b0;
      req_payload  = '0;
      unused       = '0;
      error_count  = 0;
      shadow_count = 0;
      foreach (shadow_keys[i]) shadow_keys[i] = '0;
      fill_keys = '{32'd5, 32'd1, 32'd9, 32'd3, 32'd13, 32'd2, 32'd7,
                    32'd11, 32'd4, 32'd12, 32'd6, 32'd10, 32'd8};

      // Remove from an empty store, then removal of an absent key from a
      // single-entry store, then both key extremes.
      add_row(CMD_REMOVE, 32'd0, 1, STATUS_NOT_FOUND, 0, 1, 32'd0);
      add_row(CMD_INSERT, 32'h7fff_ffff, 1, STATUS_DONE, 1, 0, 32'h7fff_ffff);
      add_row(CMD_REMOVE, 32'd5, 1, STATUS_NOT_FOUND, 1, 0, 32'h7fff_ffff);
      add_row(CMD_INSERT, 32'h8000_0000, 1, STATUS_DONE, 2, 0, 32'h8000_0000);
      add_row(CMD_REMOVE, 32'h8000_0000, 1, STATUS_DONE, 1, 0, 32'h7fff_ffff);
      // Duplicate keys, then fill the store to capacity.
      add_row(CMD_INSERT, 32'hffff_ffff, 0, STATUS_DONE, 0, 0, 32'd0);
      add_row(CMD_INSERT, 32'hffff_ffff, 0, STATUS_DONE, 0, 0, 32'd0);
      add_row(CMD_REMOVE, 32'hffff_ffff, 0, STATUS_DONE, 0, 0, 32'd0);
      add_row(CMD_INSERT, 32'd0, 0, STATUS_DONE, 0, 0, 32'd0);
      foreach (fill_keys[i]) add_row(CMD_INSERT, fill_keys[i], 0, STATUS_DONE, 0, 0, 32'd0);
      // Insert into a full store is refused and changes nothing.
      add_row(CMD_INSERT, 32'h8000_0000, 1, STATUS_FULL, 16, 0, 32'hffff_ffff);
      add_row(CMD_REMOVE, 32'h7fff_ffff, 0, STATUS_DONE, 0, 0, 32'd0);
      add_row(CMD_REMOVE, 32'd3, 0, STATUS_DONE, 0, 0, 32'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i].op, directed_rows[i].typed,
                                              directed_rows[i].want);

      // Random part: the insert share is drawn anew every 80 requests so the
      // store swings between empty and full.
      insert_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 80 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 15;
               1: insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         op.command = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
         op.key     = pick_key();
         send_request(op, 0, unused);
      end
      req_valid <= 1'b0;

      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, awaited_responses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
